### sv/cpf_check_digit_validator_top_assert.svh
// Assertion macros for the CPF check-digit validator.
`ifndef CPF_CHECK_DIGIT_VALIDATOR_TOP_ASSERT_SVH
`define CPF_CHECK_DIGIT_VALIDATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define CPFV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define CPFV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cpfv_pkg.sv
`default_nettype none

package cpfv_pkg;

  localparam int IdW    = 37;
  localparam int DigN   = 11;
  localparam int BcdW   = 4 * DigN;
  localparam int DdBits = 8;                          // conversion steps per stage
  localparam int DdStg  = (IdW + DdBits - 1) / DdBits;
  localparam int NStg   = DdStg + 3;                  // input, conversion, sums, check
  localparam int SumW   = 10;

  localparam logic [IdW-1:0] IdMax = 37'd99999999999;

  typedef logic [IdW-1:0]  id_t;
  typedef logic [BcdW-1:0] bcd_t;
  typedef logic [SumW-1:0] sum_t;

  // One shift-add-3 step: correct every digit, then shift in the next binary bit.
  function automatic bcd_t dd_step(bcd_t b, logic nb);
    bcd_t c;
    c = b;
    for (int i = 0; i < DigN; i++) begin
      if (c[4*i +: 4] >= 4'd5) begin
        c[4*i +: 4] = c[4*i +: 4] + 4'd3;
      end
    end
    return {c[BcdW-2:0], nb};
  endfunction

  // s mod 11 for s < 1024: fold 64 = 9 (mod 11), then 16 = 5, then compare-subtract.
  function automatic logic [3:0] mod11(sum_t s);
    logic [7:0] t;
    logic [6:0] u;
    t = 8'({4'd0, s[9:6]} * 8'd9) + {2'd0, s[5:0]};
    u = 7'({3'd0, t[7:4]} * 7'd5) + {3'd0, t[3:0]};
    if (u >= 7'd44) u = u - 7'd44;
    if (u >= 7'd22) u = u - 7'd22;
    if (u >= 7'd11) u = u - 7'd11;
    return u[3:0];
  endfunction

  function automatic logic [3:0] exp_digit(logic [3:0] r);
    return (r < 4'd2) ? 4'd0 : 4'd11 - r;
  endfunction

endpackage

`default_nettype wire

### sv/cpfv_if.sv
`default_nettype none

interface cpfv_in_if;
  import cpfv_pkg::*;

  logic valid;
  logic ready;
  id_t  id_number;

  modport source (output valid, output id_number, input ready);
  modport sink   (input valid, input id_number, output ready);
endinterface

interface cpfv_out_if;
  import cpfv_pkg::*;

  logic valid;
  logic ready;
  logic is_valid;
  id_t  accepted_number;

  modport source (output valid, output is_valid, output accepted_number, input ready);
  modport sink   (input valid, input is_valid, input accepted_number, output ready);
endinterface

`default_nettype wire

### sv/cpf_check_digit_validator_top.sv
// CPF check-digit validator (mod-11, two check digits).
//
// in_i  : one beat carries id_number, the binary value of an 11-digit identifier.
// out_o : one beat per input beat, in order: is_valid, and accepted_number, which
//         is id_number when valid and zero otherwise. Values above 99999999999
//         are always rejected.
//
// An accepted input beat reaches the result beat through one input register,
// five binary-to-BCD stages of up to eight shift-add-3 steps each (the last
// takes the low five bits), one stage for the two weighted digit sums and one
// for the mod-11 reduction and compare. Throughput is one beat per cycle
// while out_o.ready is high; the conversion stages set the depth.
//
// Every stage carries its own valid bit and loads when it is empty or when the
// stage after it moves, so bubbles close up and in_i.ready can stay high while
// a result waits at the output. When out_o.ready is low the result holds and the
// pipe fills; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties the pipe; there is no other state.
`default_nettype none

module cpf_check_digit_validator_top (
  input  wire               clk_i,
  input  wire               rst_ni,
  cpfv_in_if.sink           in_i,
  cpfv_out_if.source        out_o
);
  import cpfv_pkg::*;

  logic [NStg-1:0] vld_q;
  logic [NStg-1:0] en;

  id_t  num_q [NStg];
  logic ovf_q [NStg-1];
  bcd_t bcd_q [1:DdStg];
  sum_t s1_q, s2_q;
  logic [3:0] d10_q, d11_q;
  logic ok_q;

  // A stage moves when empty or when the next one moves.
  always_comb begin
    en[NStg-1] = !vld_q[NStg-1] || out_o.ready;
    for (int k = NStg - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < NStg; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // Input register and range flag.
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      num_q[0] <= in_i.id_number;
      ovf_q[0] <= in_i.id_number > IdMax;
    end
  end

  // Number and range flag travel alongside the data.
  for (genvar k = 1; k < NStg; k++) begin : g_carry
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        num_q[k] <= num_q[k-1];
      end
    end
    if (k < NStg - 1) begin : g_ovf
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          ovf_q[k] <= ovf_q[k-1];
        end
      end
    end
  end

  // Binary to BCD, up to eight bits per stage, most significant bit first.
  for (genvar k = 1; k <= DdStg; k++) begin : g_dd
    bcd_t chain [DdBits+1];
    if (k == 1) begin : g_first
      assign chain[0] = '0;
    end else begin : g_next
      assign chain[0] = bcd_q[k-1];
    end
    for (genvar j = 0; j < DdBits; j++) begin : g_step
      localparam int Pos = IdW - 1 - (k - 1) * DdBits - j;
      if (Pos >= 0) begin : g_bit
        assign chain[j+1] = dd_step(chain[j], num_q[k-1][Pos]);
      end else begin : g_pass
        assign chain[j+1] = chain[j];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        bcd_q[k] <= chain[DdBits];
      end
    end
  end

  // Weighted sums; digit i counts from the least significant end.
  sum_t s1_d, s2_d;
  always_comb begin
    s1_d = '0;
    s2_d = '0;
    for (int i = 1; i <= DigN - 1; i++) begin
      if (i >= 2) begin
        s1_d = s1_d + sum_t'({6'd0, bcd_q[DdStg][4*i +: 4]} * sum_t'(i));
      end
      s2_d = s2_d + sum_t'({6'd0, bcd_q[DdStg][4*i +: 4]} * sum_t'(i + 1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[DdStg+1]) begin
      s1_q  <= s1_d;
      s2_q  <= s2_d;
      d10_q <= bcd_q[DdStg][7:4];
      d11_q <= bcd_q[DdStg][3:0];
    end
  end

  logic ok_d;
  assign ok_d = !ovf_q[DdStg+1]
             && (d10_q == exp_digit(mod11(s1_q)))
             && (d11_q == exp_digit(mod11(s2_q)));

  always_ff @(posedge clk_i) begin
    if (en[NStg-1]) begin
      ok_q <= ok_d;
    end
  end

  assign out_o.valid           = vld_q[NStg-1];
  assign out_o.is_valid        = ok_q;
  assign out_o.accepted_number = ok_q ? num_q[NStg-1] : '0;

endmodule

`default_nettype wire

### sv/cpfv_chk.sv
`default_nettype none

`include "cpf_check_digit_validator_top_assert.svh"

module cpfv_chk (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_ready,
  input wire                out_valid,
  input wire                out_ready,
  input wire                out_is_valid,
  input wire cpfv_pkg::id_t out_accepted_number
);
  import cpfv_pkg::*;

  `CPFV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result beat dropped while stalled")
  `CPFV_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_accepted_number) && $stable(out_is_valid), "stalled result changed")
  `CPFV_ASSERT_NOW(a_reject_zero, out_valid && !out_is_valid, out_accepted_number == '0, "rejected beat carries a number")
  `CPFV_ASSERT_NOW(a_accept_range, out_valid && out_is_valid, out_accepted_number <= IdMax, "accepted number beyond eleven digits")
  `CPFV_ASSERT_NOW(a_ready_free, !out_valid, in_ready, "input stalled with empty output")

endmodule

bind cpf_check_digit_validator_top cpfv_chk u_cpfv_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .in_ready            (in_i.ready),
  .out_valid           (out_o.valid),
  .out_ready           (out_o.ready),
  .out_is_valid        (out_o.is_valid),
  .out_accepted_number (out_o.accepted_number)
);

`default_nettype wire
